>>> hdl/boundary_tag_heap_allocator_macros.svh
// assertion macros used by the checker file
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH

// clocked assertion, muted while reset is high
`define BTHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also watches the reset cycles
`define BTHA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/bhta_pkg.sv
// shared constants and types of the boundary tag heap allocator
package bhta_pkg;

  // default heap size in bytes
  localparam int HEAP_BYTES_DEF = 4096;

  // boundary tag layout: size byte, in-use byte, payload, trailer byte
  localparam int TAG_USE  = 1;
  localparam int TAG_HEAD = 2;
  localparam int TAG_ALL  = 3;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // store port strobes from the sequencer
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

>>> hdl/bhta_ram.sv
// generic single-write, single-read ram with registered read data
module bhta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bhta_ctrl.sv
// sequencer that walks, tags, zeroes and trims blocks in the heap store
module bhta_ctrl #(
  parameter int HEAP_BYTES = bhta_pkg::HEAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          mode,
  input  logic [7:0]                    request_size,
  input  logic [31:0]                   free_address,
  input  logic [31:0]                   base_addr,
  output logic                          busy,
  output logic                          done,
  output logic [31:0]                   block_address,
  output logic [1:0]                    status,
  output bhta_pkg::mem_ctl_t            mem_ctl,
  output logic [$clog2(HEAP_BYTES)-1:0] waddr,
  output logic [7:0]                    wdata,
  output logic [$clog2(HEAP_BYTES)-1:0] raddr,
  input  logic [7:0]                    rdata
);
  import bhta_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int OW = $clog2(HEAP_BYTES + 1);
  localparam int XW = $clog2(HEAP_BYTES + 512);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_A_SZ  = 4'd3;
  localparam logic [3:0] S_A_USE = 4'd4;
  localparam logic [3:0] S_AP_HD = 4'd5;
  localparam logic [3:0] S_A_TRL = 4'd6;
  localparam logic [3:0] S_A_MRK = 4'd7;
  localparam logic [3:0] S_F_CHK = 4'd8;
  localparam logic [3:0] S_F_SZ  = 4'd9;
  localparam logic [3:0] S_F_ZRO = 4'd10;
  localparam logic [3:0] S_T_RD  = 4'd11;
  localparam logic [3:0] S_T_USE = 4'd12;
  localparam logic [3:0] S_T_SZ  = 4'd13;
  localparam logic [3:0] S_T_TRL = 4'd14;
  localparam logic [3:0] S_T_PSZ = 4'd15;

  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [OW-1:0] top;
  logic [XW-1:0] pos;
  logic [7:0]    size_r;
  logic [7:0]    sz_r;
  logic [7:0]    cnt;
  logic [31:0]   free_addr_r;
  logic          rd_oob;

  logic          rd_en;
  logic [XW-1:0] rd_addr_x;
  logic          wr_en;
  logic [XW-1:0] wr_addr_x;
  logic [7:0]    wr_data_x;
  logic [7:0]    rbyte;
  logic [31:0]   off;
  logic          off_ok;
  logic [XW-1:0] top_x;
  logic [XW-1:0] heap_x;

  assign top_x  = XW'(top);
  assign heap_x = XW'(HEAP_BYTES);
  assign busy   = (state != S_IDLE);

  // bytes beyond the store read as zero
  assign rbyte = rd_oob ? 8'd0 : rdata;

  // free offset and its range check
  assign off    = free_addr_r - base_addr;
  assign off_ok = (off < 32'(top)) && (off >= 32'(TAG_HEAD));

  // store command per state; each entry is touched at most once per cycle
  // and reads come in later states than the writes they depend on
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_x = pos;
    wr_en     = 1'b0;
    wr_addr_x = pos;
    wr_data_x = 8'd0;
    unique case (state)
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr_x = XW'(clr_cnt);
      end
      S_A_CHK: begin
        rd_en = (size_r != 8'd0) && (pos < top_x);
      end
      S_A_SZ: begin
        rd_en     = 1'b1;
        rd_addr_x = pos + XW'(TAG_USE);
      end
      S_AP_HD: begin
        wr_en     = 1'b1;
        wr_data_x = size_r;
      end
      S_A_TRL: begin
        wr_en     = 1'b1;
        wr_addr_x = pos + XW'(TAG_HEAD) + XW'(size_r);
        wr_data_x = size_r;
      end
      S_A_MRK: begin
        wr_en     = 1'b1;
        wr_addr_x = pos + XW'(TAG_USE);
        wr_data_x = 8'd1;
      end
      S_F_CHK: begin
        rd_en     = off_ok;
        rd_addr_x = XW'(off - 32'(TAG_HEAD));
      end
      S_F_SZ: begin
        wr_en     = 1'b1;
        wr_addr_x = pos + XW'(TAG_USE);
      end
      S_F_ZRO: begin
        wr_en     = (cnt != sz_r);
        wr_addr_x = pos + XW'(TAG_HEAD) + XW'(cnt);
      end
      S_T_RD: begin
        rd_en     = 1'b1;
        rd_addr_x = pos + XW'(TAG_USE);
      end
      S_T_USE: begin
        rd_en = (rbyte == 8'd0);
      end
      S_T_SZ: begin
        wr_en = 1'b1;
      end
      S_T_TRL: begin
        wr_en     = 1'b1;
        wr_addr_x = pos + XW'(TAG_HEAD) + XW'(sz_r);
        rd_en     = (pos != '0);
        rd_addr_x = pos - XW'(1);
      end
      default: begin
      end
    endcase
  end

  // drop writes beyond the store; reads there are masked by rd_oob
  assign mem_ctl.wr = wr_en && (wr_addr_x < heap_x);
  assign mem_ctl.rd = rd_en;
  assign waddr      = wr_addr_x[AW-1:0];
  assign wdata      = wr_data_x;
  assign raddr      = rd_addr_x[AW-1:0];

  // out-of-store flag travels with the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_oob <= !(rd_addr_x < heap_x);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      top     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(HEAP_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            size_r      <= request_size;
            free_addr_r <= free_address;
            pos         <= '0;
            state       <= mode ? S_F_CHK : S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (size_r == 8'd0) begin
            block_address <= '0;
            status        <= ST_OOM;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (pos < top_x) begin
            state <= S_A_SZ;
          end else if (top_x + XW'(size_r) + XW'(TAG_ALL) > heap_x) begin
            block_address <= '0;
            status        <= ST_OOM;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            pos   <= top_x;
            state <= S_AP_HD;
          end
        end
        S_A_SZ: begin
          sz_r  <= rbyte;
          state <= S_A_USE;
        end
        S_A_USE: begin
          if (sz_r == size_r && rbyte == 8'd0) begin
            state <= S_A_TRL;
          end else begin
            pos   <= pos + XW'(sz_r) + XW'(TAG_ALL);
            state <= S_A_CHK;
          end
        end
        S_AP_HD: begin
          top   <= OW'(pos + XW'(size_r) + XW'(TAG_ALL));
          state <= S_A_TRL;
        end
        S_A_TRL: begin
          state <= S_A_MRK;
        end
        S_A_MRK: begin
          block_address <= base_addr + 32'(pos) + 32'(TAG_HEAD);
          status        <= ST_DONE;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_F_CHK: begin
          if (off_ok) begin
            pos   <= XW'(off - 32'(TAG_HEAD));
            state <= S_F_SZ;
          end else begin
            block_address <= '0;
            status        <= ST_RANGE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_F_SZ: begin
          sz_r  <= rbyte;
          cnt   <= 8'd0;
          state <= S_F_ZRO;
        end
        S_F_ZRO: begin
          // zero one payload byte a cycle, then see if this was the last block
          if (cnt != sz_r) begin
            cnt <= cnt + 8'd1;
          end else if (pos + XW'(sz_r) + XW'(TAG_ALL) == top_x) begin
            state <= S_T_RD;
          end else begin
            block_address <= '0;
            status        <= ST_DONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_T_RD: begin
          state <= S_T_USE;
        end
        S_T_USE: begin
          if (rbyte != 8'd0) begin
            block_address <= '0;
            status        <= ST_DONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_T_SZ;
          end
        end
        S_T_SZ: begin
          sz_r  <= rbyte;
          state <= S_T_TRL;
        end
        S_T_TRL: begin
          top <= OW'(pos);
          if (pos == '0) begin
            block_address <= '0;
            status        <= ST_DONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_T_PSZ;
          end
        end
        S_T_PSZ: begin
          // step back over the previous block via its trailer
          if (XW'(rbyte) + XW'(TAG_ALL) > pos) begin
            block_address <= '0;
            status        <= ST_DONE;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            pos   <= pos - XW'(rbyte) - XW'(TAG_ALL);
            state <= S_T_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/boundary_tag_heap_allocator.sv
// allocation walks the blocks, then appends at the top, reuses a free block of equal size
// or reports out of memory; free rejects an out-of-range address, else zeroes the payload
// byte by byte and, for the top block, trims free blocks off the heap top to a used block
// or offset 0; steps follow the one-read, one-write store with registered read data
// one request at a time, taken while busy is low; the 1-cycle done beat is never held back
// synchronous reset runs a clearing pass over every store byte, busy high
module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES = bhta_pkg::HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  request_size,
  input  logic [31:0] free_address,
  output logic        done,
  output logic [31:0] block_address,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import bhta_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);

  logic [31:0]   base_addr;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  // base address register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
    end else if (cfg_we) begin
      base_addr <= cfg_wdata;
    end
  end

  // request sequencer
  bhta_ctrl #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mode          (mode),
    .request_size  (request_size),
    .free_address  (free_address),
    .base_addr     (base_addr),
    .busy          (busy),
    .done          (done),
    .block_address (block_address),
    .status        (status),
    .mem_ctl       (mem_ctl),
    .waddr         (waddr),
    .wdata         (wdata),
    .raddr         (raddr),
    .rdata         (rdata)
  );

  // heap store
  bhta_ram #(
    .WIDTH (8),
    .DEPTH (HEAP_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_ctl.wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mem_ctl.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

>>> hdl/bhta_checker.sv
// port-level checker for the boundary tag heap allocator, with its bind
`include "boundary_tag_heap_allocator_macros.svh"

module bhta_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] block_address,
  input logic [1:0]  status
);
  import bhta_pkg::*;

  // reset always starts the clearing pass
  `BTHA_ASSERT_RST(a_reset_busy, rst |=> busy, "block not busy after reset")

  // an accepted request raises busy
  `BTHA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not raise busy")

  // the done beat comes with the block ready again
  `BTHA_ASSERT(a_done_idle, done |-> !busy, "done beat while still busy")

  // only known status codes are reported
  `BTHA_ASSERT(a_status_code, done |-> (status == ST_DONE || status == ST_OOM || status == ST_RANGE), "bad status code")

  // failed allocations and frees return a zero address
  `BTHA_ASSERT(a_fail_zero, (done && status != ST_DONE) |-> (block_address == 32'd0), "nonzero address on failure")

endmodule

bind boundary_tag_heap_allocator bhta_checker u_bhta_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .block_address (block_address),
  .status        (status)
);
